// ----- rtl/periodic_timer_bank_defines.svh -----
// assertion macros for the periodic timer bank
// used by the top level only; expects clk and rst_n in scope
`ifndef PERIODIC_TIMER_BANK_DEFINES_SVH
`define PERIODIC_TIMER_BANK_DEFINES_SVH
`ifndef ASSERT_OFF
`define PTB_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`define PTB_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define PTB_ASSERT_IMP(lbl, pre, post, msg)
`define PTB_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

// ----- rtl/ptb_pkg.sv -----
// shared types and constants of the periodic timer bank
// no dependencies
package ptb_pkg;

  localparam int unsigned CHANNELS_DEF = 32;
  localparam int unsigned MAX_RESULTS  = 32;
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned PERIOD_W     = 32;
  localparam int unsigned REPEAT_W     = 8;
  localparam int unsigned KIND_W       = 3;
  localparam int unsigned CHAN_W       = 5;
  localparam int unsigned TS_W         = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK    = 2'd0,
    REQ_PROGRAM = 2'd1,
    REQ_SERVICE = 2'd2,
    REQ_IGNORED = 2'd3
  } req_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK       = 3'd0,
    KIND_PROGRAMMED = 3'd1,
    KIND_REJECTED   = 3'd2,
    KIND_FIRED      = 3'd3,
    KIND_NONE       = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_PRG_SCAN,
    ST_SVC_SCAN,
    ST_SVC_EX,
    ST_SVC_END,
    ST_EMIT
  } state_t;

  typedef enum logic {
    ALU_TICK,
    ALU_SERVICE
  } alu_op_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] elapsed;
    logic [REPEAT_W-1:0] remaining;
  } chan_word_t;

  typedef struct packed {
    chan_word_t word;
    logic       active;
    logic       due;
    logic       rem_zero;
  } alu_res_t;

endpackage

// ----- rtl/ptb_if.sv -----
// request and result channel interfaces of the periodic timer bank
// depends on ptb_pkg
interface ptb_req_if
  import ptb_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [PERIOD_W-1:0] period;
  logic [REPEAT_W-1:0] repeat_count;

  modport source (output valid, output req_type, output period, output repeat_count,
                  input ready);
  modport sink (input valid, input req_type, input period, input repeat_count,
                output ready);
endinterface

interface ptb_res_if
  import ptb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAN_W-1:0] channel;
  logic [TS_W-1:0]   timestamp;
  logic              last;

  modport source (output valid, output kind, output channel, output timestamp,
                  output last, input ready);
  modport sink (input valid, input kind, input channel, input timestamp,
                input last, output ready);
endinterface

// ----- rtl/ptb_chan_mem.sv -----
// channel state memory: period, elapsed count and repeats left per channel
// one write port, one registered read port; depends on ptb_pkg
module ptb_chan_mem
  import ptb_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       we,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] waddr,
  input  chan_word_t wdata,
  input  logic       re,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] raddr,
  output chan_word_t rdata
);

  chan_word_t mem [CHANNELS];
  chan_word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/ptb_chan_alu.sv -----
// shared channel update unit: due compare, elapsed step, repeat count step
// combinational; depends on ptb_pkg
module ptb_chan_alu
  import ptb_pkg::*;
(
  input  alu_op_t    op,
  input  chan_word_t word,
  input  logic       keep_count,
  output alu_res_t   res
);

  always_comb begin
    res.active   = (word.period != '0);
    res.due      = (word.period <= word.elapsed);
    res.rem_zero = (word.remaining == '0);
    res.word     = word;
    unique case (op)
      ALU_TICK: begin
        if (res.due) begin
          res.word.elapsed = PERIOD_W'(1);
        end else begin
          res.word.elapsed = word.elapsed + PERIOD_W'(1);
        end
      end
      ALU_SERVICE: begin
        res.word.elapsed = '0;
        if (!keep_count) begin
          res.word.remaining = word.remaining - REPEAT_W'(1);
        end
      end
      default: begin
        res.word = word;
      end
    endcase
  end

endmodule

// ----- rtl/periodic_timer_bank.sv -----
// periodic timer bank top level: sequencer, channel flags and result register
// depends on ptb_pkg, ptb_if, ptb_chan_mem, ptb_chan_alu, periodic_timer_bank_defines.svh
//
// usage: requests come in on in_if (tick, program, service), results leave on out_if.
// one request is worked at a time; in_if.ready is high only while the block is idle.
// a tick walks every channel through the shared update unit, one channel per cycle,
// pipelined behind the registered memory read, and ends with the tick word.
// a program request scans the in-use flags one per cycle.
// a service request steps past each idle channel and reads and updates each pending one,
// then ends the scan and loads the closing word; every fire is one result word, the
// final word of a request carries last.
// results sit in an output register, so a new request is taken while the previous
// result still waits; if the receiver stalls, the sequencer holds in place until the
// register frees up and nothing is dropped.
// reset (rst_n low, synchronous) frees every channel, clears the pending mask and the
// tick count; the memory needs no clearing since a free channel is never read as live.
`include "periodic_timer_bank_defines.svh"
module periodic_timer_bank
  import ptb_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ptb_req_if.sink   in_if,
  ptb_res_if.source out_if
);

  localparam int unsigned IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CW  = $clog2(CHANNELS + 1);
  localparam int unsigned FCW = $clog2(MAX_RESULTS + 1);

  state_t              state_r, state_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                ex_valid_r, ex_valid_nxt;
  logic [IW-1:0]       ex_idx_r, ex_idx_nxt;
  logic [PERIOD_W-1:0] per_r, per_nxt;
  logic [REPEAT_W-1:0] rep_r, rep_nxt;
  logic [TS_W-1:0]     now_r, now_nxt;
  logic [CHANNELS-1:0] in_use_r, in_use_nxt;
  logic [CHANNELS-1:0] forever_r, forever_nxt;
  logic [CHANNELS-1:0] pending_r, pending_nxt;
  logic                hold_valid_r, hold_valid_nxt;
  logic [IW-1:0]       hold_chan_r, hold_chan_nxt;
  logic [FCW-1:0]      fire_cnt_r, fire_cnt_nxt;
  kind_t               res_kind_r, res_kind_nxt;
  logic [CHAN_W-1:0]   res_chan_r, res_chan_nxt;

  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [CHAN_W-1:0]   out_chan_r, out_chan_nxt;
  logic                out_last_r, out_last_nxt;
  logic [TS_W-1:0]     out_ts_r, out_ts_nxt;

  logic                out_free;
  logic                out_load;
  kind_t               load_kind;
  logic [CHAN_W-1:0]   load_chan;
  logic                load_last;

  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  chan_word_t          mem_wdata, mem_rdata;

  alu_op_t             alu_op;
  logic                alu_keep;
  alu_res_t            alu_res;

  logic [IW-1:0]       cur;

  ptb_chan_mem #(
    .CHANNELS(CHANNELS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  ptb_chan_alu u_alu (
    .op        (alu_op),
    .word      (mem_rdata),
    .keep_count(alu_keep),
    .res       (alu_res)
  );

  assign in_if.ready      = (state_r == ST_IDLE);
  assign out_if.valid     = out_valid_r;
  assign out_if.kind      = out_kind_r;
  assign out_if.channel   = out_chan_r;
  assign out_if.timestamp = out_ts_r;
  assign out_if.last      = out_last_r;

  assign out_free = !out_valid_r || out_if.ready;
  assign cur      = idx_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ex_valid_r   <= 1'b0;
      now_r        <= '0;
      in_use_r     <= '0;
      forever_r    <= '0;
      pending_r    <= '0;
      hold_valid_r <= 1'b0;
      fire_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ex_valid_r   <= ex_valid_nxt;
      now_r        <= now_nxt;
      in_use_r     <= in_use_nxt;
      forever_r    <= forever_nxt;
      pending_r    <= pending_nxt;
      hold_valid_r <= hold_valid_nxt;
      fire_cnt_r   <= fire_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    ex_idx_r    <= ex_idx_nxt;
    per_r       <= per_nxt;
    rep_r       <= rep_nxt;
    hold_chan_r <= hold_chan_nxt;
    res_kind_r  <= res_kind_nxt;
    res_chan_r  <= res_chan_nxt;
    out_kind_r  <= out_kind_nxt;
    out_chan_r  <= out_chan_nxt;
    out_last_r  <= out_last_nxt;
    out_ts_r    <= out_ts_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    ex_valid_nxt   = ex_valid_r;
    ex_idx_nxt     = ex_idx_r;
    per_nxt        = per_r;
    rep_nxt        = rep_r;
    now_nxt        = now_r;
    in_use_nxt     = in_use_r;
    forever_nxt    = forever_r;
    pending_nxt    = pending_r;
    hold_valid_nxt = hold_valid_r;
    hold_chan_nxt  = hold_chan_r;
    fire_cnt_nxt   = fire_cnt_r;
    res_kind_nxt   = res_kind_r;
    res_chan_nxt   = res_chan_r;

    out_load  = 1'b0;
    load_kind = KIND_NONE;
    load_chan = '0;
    load_last = 1'b1;

    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = alu_res.word;
    mem_re    = 1'b0;
    mem_raddr = cur;

    alu_op    = ALU_TICK;
    alu_keep  = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          per_nxt        = in_if.period;
          rep_nxt        = in_if.repeat_count;
          idx_nxt        = '0;
          ex_valid_nxt   = 1'b0;
          fire_cnt_nxt   = '0;
          hold_valid_nxt = 1'b0;
          unique case (req_t'(in_if.req_type))
            REQ_TICK: begin
              now_nxt   = now_r + TS_W'(1);
              state_nxt = ST_TICK;
            end
            REQ_PROGRAM: begin
              state_nxt = ST_PRG_SCAN;
            end
            REQ_SERVICE: begin
              state_nxt = ST_SVC_SCAN;
            end
            REQ_IGNORED: begin
              res_kind_nxt = KIND_NONE;
              res_chan_nxt = '0;
              state_nxt    = ST_EMIT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_TICK: begin
        // read channel idx while updating the one read last cycle
        ex_valid_nxt = (idx_r < CW'(CHANNELS));
        ex_idx_nxt   = cur;
        if (idx_r < CW'(CHANNELS)) begin
          mem_re  = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end
        if (ex_valid_r) begin
          alu_op    = ALU_TICK;
          mem_waddr = ex_idx_r;
          if (in_use_r[ex_idx_r] && alu_res.active) begin
            mem_we = 1'b1;
            if (alu_res.due) begin
              pending_nxt[ex_idx_r] = 1'b1;
            end
          end
        end
        if ((idx_r == CW'(CHANNELS)) && !ex_valid_r) begin
          res_kind_nxt = KIND_TICK;
          res_chan_nxt = '0;
          state_nxt    = ST_EMIT;
        end
      end

      ST_PRG_SCAN: begin
        if (idx_r == CW'(CHANNELS)) begin
          res_kind_nxt = KIND_REJECTED;
          res_chan_nxt = '0;
          state_nxt    = ST_EMIT;
        end else if (!in_use_r[cur]) begin
          mem_we            = 1'b1;
          mem_wdata         = '{period: per_r, elapsed: '0, remaining: rep_r};
          in_use_nxt[cur]   = 1'b1;
          forever_nxt[cur]  = (rep_r == '0);
          res_kind_nxt      = KIND_PROGRAMMED;
          res_chan_nxt      = CHAN_W'(cur);
          state_nxt         = ST_EMIT;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      ST_SVC_SCAN: begin
        if (idx_r == CW'(CHANNELS)) begin
          state_nxt = ST_SVC_END;
        end else if (!pending_r[cur]) begin
          idx_nxt = idx_r + CW'(1);
        end else if (fire_cnt_r == FCW'(MAX_RESULTS)) begin
          state_nxt = ST_SVC_END;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_SVC_EX;
        end
      end

      ST_SVC_EX: begin
        alu_op   = ALU_SERVICE;
        alu_keep = forever_r[cur];
        if (!forever_r[cur] && alu_res.rem_zero) begin
          // exhausted finite channel: free it and end the scan
          pending_nxt[cur] = 1'b0;
          in_use_nxt[cur]  = 1'b0;
          state_nxt        = ST_SVC_END;
        end else if (!hold_valid_r || out_free) begin
          if (hold_valid_r) begin
            out_load  = 1'b1;
            load_kind = KIND_FIRED;
            load_chan = CHAN_W'(hold_chan_r);
            load_last = 1'b0;
          end
          mem_we           = 1'b1;
          pending_nxt[cur] = 1'b0;
          hold_valid_nxt   = 1'b1;
          hold_chan_nxt    = cur;
          fire_cnt_nxt     = fire_cnt_r + FCW'(1);
          idx_nxt          = idx_r + CW'(1);
          state_nxt        = ST_SVC_SCAN;
        end
      end

      ST_SVC_END: begin
        if (out_free) begin
          out_load       = 1'b1;
          load_kind      = hold_valid_r ? KIND_FIRED : KIND_NONE;
          load_chan      = hold_valid_r ? CHAN_W'(hold_chan_r) : '0;
          load_last      = 1'b1;
          hold_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_kind = res_kind_r;
          load_chan = res_chan_r;
          load_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_chan_nxt  = out_chan_r;
    out_last_nxt  = out_last_r;
    out_ts_nxt    = out_ts_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = load_kind;
      out_chan_nxt  = load_chan;
      out_last_nxt  = load_last;
      out_ts_nxt    = now_r;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  `PTB_ASSERT_IMP(a_pending_in_use, 1'b1, (pending_r & ~in_use_r) == '0, "pending on free channel")
  `PTB_ASSERT_IMP(a_fire_limit, 1'b1, fire_cnt_r <= FCW'(MAX_RESULTS), "fire count over limit")
  `PTB_ASSERT_IMP(a_hold_in_service, hold_valid_r, (state_r == ST_SVC_SCAN) || (state_r == ST_SVC_EX) || (state_r == ST_SVC_END), "held fire outside service")
  `PTB_ASSERT_NXT(a_tick_advance, in_if.valid && in_if.ready && (in_if.req_type == REQ_TICK), now_r == $past(now_r) + TS_W'(1), "tick did not advance time")

endmodule

// ----- tb/ptb_timer_checker.sv -----
`timescale 1ns / 1ps
// result checker for the periodic timer bank: models the channel bank, compares each word
// depends on ptb_pkg and the ptb_req_if / ptb_res_if interfaces
module ptb_timer_checker
  import ptb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ptb_req_if        req_bus,
  ptb_res_if        res_bus,
  output int        fail_count,
  output int        words_owed
);

  typedef struct {
    kind_t             kind;
    logic [CHAN_W-1:0] channel;
    logic [TS_W-1:0]   timestamp;
    logic              last;
  } timer_word_t;

  logic [TS_W-1:0]     tick_count;
  logic [PERIOD_W-1:0] chan_period [CHANNELS_DEF];
  logic [PERIOD_W-1:0] chan_elapsed [CHANNELS_DEF];
  logic [REPEAT_W-1:0] chan_left [CHANNELS_DEF];
  logic                chan_forever [CHANNELS_DEF];
  logic                chan_busy [CHANNELS_DEF];
  logic                chan_pending [CHANNELS_DEF];

  timer_word_t expected_words [$];
  int          mismatches = 0;
  int          owed = 0;

  assign fail_count = mismatches;
  assign words_owed = owed;

  function automatic void clear_bank();
    int c;
    tick_count = '0;
    for (c = 0; c < CHANNELS_DEF; c++) begin
      chan_period[c]  = '0;
      chan_elapsed[c] = '0;
      chan_left[c]    = '0;
      chan_forever[c] = 1'b0;
      chan_busy[c]    = 1'b0;
      chan_pending[c] = 1'b0;
    end
  endfunction

  function automatic timer_word_t make_word(kind_t k, int c);
    timer_word_t w;
    w.kind      = k;
    w.channel   = CHAN_W'(c);
    w.timestamp = tick_count;
    w.last      = 1'b0;
    return w;
  endfunction

  function automatic void predict_request(req_t rq, logic [PERIOD_W-1:0] per,
                                          logic [REPEAT_W-1:0] rep);
    timer_word_t words [MAX_RESULTS];
    int          n;
    int          c;
    n = 0;
    case (rq)
      REQ_TICK: begin
        tick_count = tick_count + 1'b1;
        for (c = 0; c < CHANNELS_DEF; c++) begin
          if (chan_period[c] != '0) begin
            if (chan_period[c] <= chan_elapsed[c]) begin
              chan_elapsed[c] = 1;
              chan_pending[c] = 1'b1;
            end else begin
              chan_elapsed[c] = chan_elapsed[c] + 1'b1;
            end
          end
        end
        words[n++] = make_word(KIND_TICK, 0);
      end
      REQ_PROGRAM: begin
        for (c = 0; c < CHANNELS_DEF; c++) begin
          if (!chan_busy[c]) break;
        end
        if (c < CHANNELS_DEF) begin
          chan_period[c]  = per;
          chan_elapsed[c] = '0;
          chan_left[c]    = rep;
          chan_forever[c] = (rep == '0);
          chan_busy[c]    = 1'b1;
          words[n++] = make_word(KIND_PROGRAMMED, c);
        end else begin
          words[n++] = make_word(KIND_REJECTED, 0);
        end
      end
      REQ_SERVICE: begin
        for (c = 0; c < CHANNELS_DEF; c++) begin
          if (!chan_pending[c]) continue;
          if (n >= MAX_RESULTS) break;
          chan_pending[c] = 1'b0;
          if (chan_forever[c]) begin
            chan_elapsed[c] = '0;
            words[n++] = make_word(KIND_FIRED, c);
          end else if (chan_left[c] == '0) begin
            // expired finite channel is freed and ends the scan
            chan_period[c] = '0;
            chan_busy[c]   = 1'b0;
            break;
          end else begin
            chan_left[c]    = chan_left[c] - 1'b1;
            chan_elapsed[c] = '0;
            words[n++] = make_word(KIND_FIRED, c);
          end
        end
        if (n == 0) words[n++] = make_word(KIND_NONE, 0);
      end
      default: begin
        words[n++] = make_word(KIND_NONE, 0);
      end
    endcase
    words[n-1].last = 1'b1;
    for (c = 0; c < n; c++) expected_words.push_back(words[c]);
  endfunction

  task automatic report_mismatch(string what, logic [TS_W-1:0] got, logic [TS_W-1:0] want);
    $display("%0t ns: result mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  initial clear_bank();

  always @(posedge clk) begin
    timer_word_t want;
    if (!rst_n) begin
      clear_bank();
      expected_words.delete();
    end else begin
      if (req_bus.valid && req_bus.ready)
        predict_request(req_t'(req_bus.req_type), req_bus.period, req_bus.repeat_count);
      if (res_bus.valid && res_bus.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with none expected, kind", res_bus.kind, '0);
        end else begin
          want = expected_words.pop_front();
          if (res_bus.kind !== want.kind) report_mismatch("kind", res_bus.kind, want.kind);
          if (res_bus.channel !== want.channel)
            report_mismatch("channel", res_bus.channel, want.channel);
          if (res_bus.timestamp !== want.timestamp)
            report_mismatch("timestamp", res_bus.timestamp, want.timestamp);
          if (res_bus.last !== want.last) report_mismatch("last", res_bus.last, want.last);
        end
      end
    end
    owed = expected_words.size();
  end

endmodule

// ----- tb/tb_periodic_timer_bank.sv -----
`timescale 1ns / 1ps
// top of the periodic timer bank testbench: clock, reset, request stimulus, result stalls
// depends on ptb_pkg, the ptb interfaces, periodic_timer_bank and ptb_timer_checker
module tb_periodic_timer_bank;
  import ptb_pkg::*;

  localparam int RANDOM_REQUESTS = 110;
  localparam int IDLE_LIMIT      = 3000;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 2 * CHANNELS_DEF + 16;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   words_owed;
  int   burst_left = 0;
  int   idle_cycles = 0;
  bit   hold_off = 1'b0;

  ptb_req_if in_bus ();
  ptb_res_if out_bus ();

  periodic_timer_bank dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  ptb_timer_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_bus    (in_bus),
    .res_bus    (out_bus),
    .fail_count (fail_count),
    .words_owed (words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // offer one word and return at the falling edge after it is taken
  task automatic issue(req_t rq, logic [PERIOD_W-1:0] per, logic [REPEAT_W-1:0] rep);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    in_bus.valid        <= 1'b1;
    in_bus.req_type     <= rq;
    in_bus.period       <= per;
    in_bus.repeat_count <= rep;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (words_owed != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int                  sent;
    int                  pick;
    req_t                rq;
    logic [PERIOD_W-1:0] per;
    logic [REPEAT_W-1:0] rep;
    in_bus.valid        = 1'b0;
    in_bus.req_type     = REQ_TICK;
    in_bus.period       = '0;
    in_bus.repeat_count = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty bank, ignored request, first tick
    issue(REQ_SERVICE, '0, '0);
    issue(REQ_IGNORED, '1, '1);
    issue(REQ_TICK, '0, '0);
    // forever, never-firing, single-shot, longest period, two-shot
    issue(REQ_PROGRAM, 32'd1, 8'd0);
    issue(REQ_PROGRAM, 32'd0, 8'd5);
    issue(REQ_PROGRAM, 32'd2, 8'd1);
    issue(REQ_PROGRAM, '1, 8'd255);
    issue(REQ_PROGRAM, 32'd1, 8'd2);
    repeat (4) issue(REQ_TICK, '0, '0);
    issue(REQ_SERVICE, '0, '0);
    repeat (3) issue(REQ_TICK, '0, '0);
    // expired single-shot channel frees and stops the scan
    issue(REQ_SERVICE, '0, '0);
    issue(REQ_SERVICE, '0, '0);
    issue(REQ_PROGRAM, 32'd3, 8'd0);
    repeat (2) issue(REQ_TICK, '0, '0);
    issue(REQ_SERVICE, '0, '0);

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      if (sent < 40)
        rq = (pick < 80) ? REQ_PROGRAM : (pick < 90) ? REQ_TICK :
             (pick < 98) ? REQ_SERVICE : REQ_IGNORED;
      else
        rq = (pick < 15) ? REQ_PROGRAM : (pick < 60) ? REQ_TICK :
             (pick < 96) ? REQ_SERVICE : REQ_IGNORED;
      case ($urandom_range(0, 19))
        0, 1:       per = '0;
        2, 3, 4:    per = $urandom();
        5, 6:       per = '1;
        7, 8, 9:    per = $urandom_range(5, 20);
        default:    per = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: rep = '0;
        7, 8:                rep = '1;
        9, 10, 11:           rep = REPEAT_W'($urandom_range(0, 255));
        default:             rep = REPEAT_W'($urandom_range(1, 3));
      endcase
      if (sent == 60) hold_off = 1'b1;
      if (sent == 95) drain();
      issue(rq, per, rep);
      if (rq != REQ_IGNORED) sent++;
    end

    in_bus.valid <= 1'b0;
    while (words_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb_periodic_timer_bank OK");
    else
      $display("tb_periodic_timer_bank NOT OK");
    $finish;
  end

  initial begin : result_stalls
    logic [15:0] ready_pattern;
    logic [3:0]  phase;
    int          stretch_left;
    bit          hold_done;
    ready_pattern = '1;
    phase = '0;
    stretch_left = 0;
    hold_done = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off && !hold_done) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(20, 80);
          case ($urandom_range(0, 3))
            0:       ready_pattern = '1;
            1:       ready_pattern = 16'($urandom());
            2:       ready_pattern = 16'($urandom() | $urandom());
            default: ready_pattern = 16'($urandom() & $urandom());
          endcase
        end
        out_bus.ready <= ready_pattern[phase];
        phase = phase + 1'b1;
        stretch_left--;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_periodic_timer_bank NOT OK");
        $finish;
      end
    end
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ptb_pkg.sv
rtl/ptb_if.sv
rtl/ptb_chan_mem.sv
rtl/ptb_chan_alu.sv
rtl/periodic_timer_bank.sv
tb/ptb_timer_checker.sv
tb/tb_periodic_timer_bank.sv
